// File: sv/hcrd_pkg.sv
package hcrd_pkg;

    localparam int DEVICES = 2;
    localparam int SLOTS   = 4;
    localparam int DEV_W   = 1;
    localparam int SLOT_W  = 2;
    localparam int VAL_W   = 2;
    localparam int ACT_W   = 3;
    localparam int TIME_W  = 48;
    localparam int MS_W    = 16;
    localparam int CFG_W   = 1;

    localparam logic [SLOTS-1:0] SHIFT_KEYS = 4'b0011;
    localparam logic [SLOTS-1:0] ENTER_KEYS = 4'b1100;

    localparam logic [MS_W-1:0] HOLD_MS_RESET     = 16'd1500;
    localparam logic [MS_W-1:0] MAX_WAIT_MS_RESET = 16'd1000;

    typedef enum logic [ACT_W-1:0] {
        ACT_KEY        = 3'd0,
        ACT_POLL       = 3'd1,
        ACT_INHIBIT    = 3'd2,
        ACT_RESYNC     = 3'd3,
        ACT_DISCONNECT = 3'd4
    } action_t;

    typedef enum logic [VAL_W-1:0] {
        KEY_RELEASE = 2'd0,
        KEY_PRESS   = 2'd1
    } key_value_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_HOLD_MS     = 1'd0,
        CFG_MAX_WAIT_MS = 1'd1
    } cfg_index_t;

endpackage

// File: sv/hcrd_if.sv
interface hcrd_item_if
    import hcrd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [DEV_W-1:0]  device;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  key_value;
    logic [TIME_W-1:0] time_ms;
    logic [SLOTS-1:0]  snapshot;

    modport source (output valid, action, device, slot, key_value, time_ms, snapshot,
                    input ready);
    modport sink   (input valid, action, device, slot, key_value, time_ms, snapshot,
                    output ready);
endinterface

interface hcrd_result_if
    import hcrd_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            fire;
    logic            timing_now;
    logic            armed_now;
    logic            inhibited_now;
    logic [MS_W-1:0] wait_ms;

    modport source (output valid, fire, timing_now, armed_now, inhibited_now, wait_ms,
                    input ready);
    modport sink   (input valid, fire, timing_now, armed_now, inhibited_now, wait_ms,
                    output ready);
endinterface

// File: sv/hold_chord_release_detector.sv
// Channel | Direction | Beat contents
// item    | in        | action, device, slot, key_value, time_ms, snapshot
// result  | out       | fire, timing_now, armed_now, inhibited_now, wait_ms
// cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One beat is accepted per cycle unless the result stalls with the input register
// full. The rate is set by the single pass from the input register through the
// 48-bit elapsed-time subtract and wait compare into the result register.
// Reset releases all keys, clears the state and valid flags, loads config defaults.
// A stalled result holds its register; the input register still drains into it
// in the cycle the result is taken.
module hold_chord_release_detector
    import hcrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    hcrd_item_if.sink         item,
    hcrd_result_if.source     result,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_index,
    input  logic [MS_W-1:0]   cfg_data
);

    logic [MS_W-1:0] hold_ms_reg;
    logic [MS_W-1:0] max_wait_ms_reg;

    logic              in_valid_reg;
    logic [ACT_W-1:0]  action_reg;
    logic [DEV_W-1:0]  device_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [VAL_W-1:0]  key_value_reg;
    logic [TIME_W-1:0] time_reg;
    logic [SLOTS-1:0]  snapshot_reg;

    logic [SLOTS-1:0]  key_down_reg [DEVICES];
    logic [SLOTS-1:0]  key_down_next [DEVICES];
    logic              timing_reg, timing_next;
    logic              armed_reg, armed_next;
    logic              inhibited_reg, inhibited_next;
    logic [TIME_W-1:0] hold_start_reg, hold_start_next;

    logic              out_valid_reg;
    logic              fire_reg, fire_next;
    logic              timing_out_reg, armed_out_reg, inhibited_out_reg;
    logic [MS_W-1:0]   wait_reg, wait_next;

    logic              advance;
    logic [SLOTS-1:0]  keys_old, keys_new;
    logic              chord_old, chord_new;
    logic [TIME_W:0]   diff;
    logic              time_ok;
    logic              reached;
    logic              arm_hit;
    logic              started;
    logic              dev_ok;
    logic              val_ok;
    logic [MS_W-1:0]   wait_raw;

    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg     <= HOLD_MS_RESET;
            max_wait_ms_reg <= MAX_WAIT_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOLD_MS:     hold_ms_reg     <= cfg_data;
                CFG_MAX_WAIT_MS: max_wait_ms_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            action_reg    <= item.action;
            device_reg    <= item.device;
            slot_reg      <= item.slot;
            key_value_reg <= item.key_value;
            time_reg      <= item.time_ms;
            snapshot_reg  <= item.snapshot;
        end
    end

    // Step logic
    always_comb
    begin
        keys_old = '0;
        for (int d = 0; d < DEVICES; d++)
            keys_old = keys_old | key_down_reg[d];
        chord_old = |(keys_old & SHIFT_KEYS) && |(keys_old & ENTER_KEYS);

        diff    = {1'b0, time_reg} - {1'b0, hold_start_reg};
        time_ok = !diff[TIME_W];
        reached = time_ok && ((|diff[TIME_W-1:MS_W]) || (diff[MS_W-1:0] >= hold_ms_reg));
        arm_hit = !inhibited_reg && timing_reg && chord_old && reached;

        dev_ok = (32'(device_reg) < DEVICES);
        val_ok = (key_value_reg == KEY_RELEASE) || (key_value_reg == KEY_PRESS);

        for (int d = 0; d < DEVICES; d++)
            key_down_next[d] = key_down_reg[d];
        timing_next     = timing_reg;
        armed_next      = armed_reg;
        inhibited_next  = inhibited_reg;
        hold_start_next = hold_start_reg;
        fire_next       = 1'b0;
        started         = 1'b0;

        unique case (action_reg)
            ACT_KEY:
            begin
                if (dev_ok && val_ok)
                begin
                    for (int d = 0; d < DEVICES; d++)
                        if (device_reg == DEV_W'(d))
                            key_down_next[d][slot_reg] = (key_value_reg == KEY_PRESS);
                end
            end
            ACT_RESYNC:
            begin
                if (dev_ok)
                    for (int d = 0; d < DEVICES; d++)
                        if (device_reg == DEV_W'(d))
                            key_down_next[d] = snapshot_reg;
            end
            ACT_DISCONNECT:
            begin
                if (dev_ok)
                    for (int d = 0; d < DEVICES; d++)
                        if (device_reg == DEV_W'(d))
                            key_down_next[d] = '0;
            end
            default: ;
        endcase

        keys_new = '0;
        for (int d = 0; d < DEVICES; d++)
            keys_new = keys_new | key_down_next[d];
        chord_new = |(keys_new & SHIFT_KEYS) && |(keys_new & ENTER_KEYS);

        unique case (action_reg)
            ACT_KEY:
            begin
                if (dev_ok && val_ok)
                begin
                    if (arm_hit)
                        armed_next = 1'b1;
                    if (inhibited_reg)
                    begin
                        if (keys_new == '0)
                            inhibited_next = 1'b0;
                    end
                    else if (!(armed_reg || arm_hit))
                    begin
                        if (chord_new)
                        begin
                            if (!timing_reg)
                            begin
                                timing_next     = 1'b1;
                                hold_start_next = time_reg;
                                started         = 1'b1;
                            end
                        end
                        else
                            timing_next = 1'b0;
                    end
                end
            end
            ACT_POLL:
            begin
                if (inhibited_reg)
                begin
                    if (keys_old == '0)
                        inhibited_next = 1'b0;
                end
                else if ((armed_reg || arm_hit) && keys_old == '0)
                begin
                    // Armed and everything released: fire once and disarm.
                    armed_next  = 1'b0;
                    timing_next = 1'b0;
                    fire_next   = 1'b1;
                end
                else if (arm_hit)
                    armed_next = 1'b1;
            end
            ACT_INHIBIT:
            begin
                timing_next    = 1'b0;
                armed_next     = 1'b0;
                inhibited_next = 1'b1;
            end
            ACT_RESYNC, ACT_DISCONNECT:
            begin
                if (dev_ok)
                begin
                    timing_next    = 1'b0;
                    armed_next     = 1'b0;
                    inhibited_next = 1'b1;
                end
            end
            default: ;
        endcase

        // A hold that starts on this beat has no elapsed time yet.
        if (started || !time_ok)
            wait_raw = hold_ms_reg;
        else if (reached)
            wait_raw = '0;
        else
            wait_raw = hold_ms_reg - diff[MS_W-1:0];

        if (timing_next && !armed_next && !inhibited_next && wait_raw < max_wait_ms_reg)
            wait_next = wait_raw;
        else
            wait_next = max_wait_ms_reg;
    end

    // Block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DEVICES; d++)
                key_down_reg[d] <= '0;
            timing_reg     <= 1'b0;
            armed_reg      <= 1'b0;
            inhibited_reg  <= 1'b0;
            hold_start_reg <= '0;
        end
        else if (advance)
        begin
            for (int d = 0; d < DEVICES; d++)
                key_down_reg[d] <= key_down_next[d];
            timing_reg     <= timing_next;
            armed_reg      <= armed_next;
            inhibited_reg  <= inhibited_next;
            hold_start_reg <= hold_start_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fire_reg          <= fire_next;
            timing_out_reg    <= timing_next;
            armed_out_reg     <= armed_next;
            inhibited_out_reg <= inhibited_next;
            wait_reg          <= wait_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.fire          = fire_reg;
    assign result.timing_now    = timing_out_reg;
    assign result.armed_now     = armed_out_reg;
    assign result.inhibited_now = inhibited_out_reg;
    assign result.wait_ms       = wait_reg;

    a_inhibit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        inhibited_reg |-> !timing_reg && !armed_reg)
        else $error("inhibited while timing or armed");

    a_armed_needs_timing: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> timing_reg)
        else $error("armed without timing");

    a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fire_reg |-> !armed_out_reg && !timing_out_reg)
        else $error("fire reported with chord still armed");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(time_reg)
                                     && $stable(action_reg))
        else $error("input register lost a stalled beat");

    a_fire_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fire_next |-> action_reg == ACT_POLL)
        else $error("fire raised by a non-poll beat");

endmodule
